// ===== src/lcabl_pkg.sv =====
// ----------------------------------------------------------------------------
// lcabl_pkg
// shared constants, types and controller states of the lowest common
// ancestor engine
// ----------------------------------------------------------------------------
package lcabl_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int LOG_LEVELS = 11;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LINK_W     = NODE_W + 1;
  localparam int TIME_W     = NODE_W + 1;
  localparam int CFG_W      = NODE_W + 1;
  localparam int TOP_W      = NODE_W + 1;
  localparam int STEP_LIMIT = 4 * MAX_NODES;
  localparam int STEP_W     = $clog2(STEP_LIMIT) + 1;
  localparam int LVL_W      = $clog2(LOG_LEVELS);

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(MAX_NODES);

  typedef struct packed {
    logic                             seen;
    logic [TIME_W-1:0]                entry;
    logic [LOG_LEVELS-1:0][NODE_W-1:0] anc;
  } node_row_t;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] other_node;
    logic              last;
  } in_word_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_LINK_RD,
    ST_LINK_WR,
    ST_CLEAR,
    ST_ENT_START,
    ST_ENT_LVL,
    ST_ENT_WR,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_WALK_ADV,
    ST_POP,
    ST_POP_WAIT,
    ST_Q_RDA,
    ST_Q_RDB,
    ST_Q_TEST,
    ST_LIFT_RD,
    ST_LIFT_CHK,
    ST_Q_DONE
  } state_e;

endpackage

// ===== src/lcabl_in_if.sv =====
// ----------------------------------------------------------------------------
// lcabl_in_if
// input channel: parent entries and ancestor queries
// ----------------------------------------------------------------------------
interface lcabl_in_if;
  import lcabl_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] other_node;
  logic              last;

  modport source (output valid, output kind, output node, output other_node,
                  output last, input ready);
  modport sink   (input valid, input kind, input node, input other_node,
                  input last, output ready);
endinterface

// ===== src/lcabl_out_if.sv =====
// ----------------------------------------------------------------------------
// lcabl_out_if
// output channel: lowest common ancestor of a query
// ----------------------------------------------------------------------------
interface lcabl_out_if;
  import lcabl_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink   (input valid, input ancestor, output ready);
endinterface

// ===== src/lcabl_ram.sv =====
// ----------------------------------------------------------------------------
// lcabl_ram
// simple dual port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
module lcabl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lcabl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcabl_ctrl
// sequencer over the link, cursor, node, exit and stack memories: child
// linking, depth-first build of times and ancestor rows, and lifting queries
// ----------------------------------------------------------------------------
module lcabl_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lcabl_pkg::in_word_t         in_word_i,
  input  logic [lcabl_pkg::CFG_W-1:0] node_count_i,
  input  logic                        out_busy_i,
  output logic                        res_load_o,
  output logic [lcabl_pkg::NODE_W-1:0] res_o
);
  import lcabl_pkg::*;

  state_e state_q, state_d;

  logic [NODE_W-1:0] cnt_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [TOP_W-1:0]  top_q;
  logic [STEP_W-1:0] steps_q;
  logic [TIME_W-1:0] clock_q;
  logic [NODE_W-1:0] tos_q, c_q, par_q, tgt_q, a_q, b_q, res_q;
  logic              last_q;
  logic              flush_q;
  logic [LOG_LEVELS-1:0][NODE_W-1:0] anc_q;
  logic [TIME_W-1:0] ea_q, xa_q, eb_q, xb_q;

  // memory ports
  logic              fc_we, ns_we, cur_we, node_we, exit_we, stk_we;
  logic [NODE_W-1:0] fc_waddr, ns_waddr, cur_waddr, node_waddr, exit_waddr, stk_waddr;
  logic [NODE_W-1:0] fc_raddr, ns_raddr, cur_raddr, node_raddr, exit_raddr, stk_raddr;
  logic [LINK_W-1:0] fc_wdata, ns_wdata, cur_wdata, fc_rdata, ns_rdata, cur_rdata;
  logic [TIME_W-1:0] exit_wdata, exit_rdata;
  logic [NODE_W-1:0] stk_wdata, stk_rdata;
  node_row_t         node_wdata, node_rdata;

  logic              link_ok, range_ok, a_above, b_above, up_above, at_limit;
  logic [NODE_W-1:0] lvl_val;

  assign link_ok = (in_word_i.node != '0) && (in_word_i.node != in_word_i.other_node)
                && ({1'b0, in_word_i.node} < node_count_i)
                && ({1'b0, in_word_i.other_node} < node_count_i);
  assign range_ok = ({1'b0, in_word_i.node} < node_count_i)
                 && ({1'b0, in_word_i.other_node} < node_count_i);
  assign a_above  = (ea_q <= node_rdata.entry) && (xa_q >= exit_rdata);
  assign b_above  = (node_rdata.entry <= ea_q) && (exit_rdata >= xa_q);
  assign up_above = (node_rdata.entry <= eb_q) && (exit_rdata >= xb_q);
  assign at_limit = (steps_q == STEP_W'(STEP_LIMIT));
  assign lvl_val  = node_rdata.anc[lvl_q - LVL_W'(1)];

  lcabl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_fc (
    .clk_i, .we_i(fc_we), .waddr_i(fc_waddr), .wdata_i(fc_wdata),
    .raddr_i(fc_raddr), .rdata_o(fc_rdata));
  lcabl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_ns (
    .clk_i, .we_i(ns_we), .waddr_i(ns_waddr), .wdata_i(ns_wdata),
    .raddr_i(ns_raddr), .rdata_o(ns_rdata));
  lcabl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(cur_waddr), .wdata_i(cur_wdata),
    .raddr_i(cur_raddr), .rdata_o(cur_rdata));
  lcabl_ram #(.WIDTH($bits(node_row_t)), .DEPTH(MAX_NODES)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata));
  lcabl_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_exit (
    .clk_i, .we_i(exit_we), .waddr_i(exit_waddr), .wdata_i(exit_wdata),
    .raddr_i(exit_raddr), .rdata_o(exit_rdata));
  lcabl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (cnt_q == NODE_W'(MAX_NODES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.kind == KIND_QUERY) begin
            state_d = range_ok ? ST_Q_RDA : ST_Q_DONE;
          end else if (link_ok) begin
            state_d = ST_LINK_RD;
          end else if (in_word_i.last) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_LINK_RD: state_d = ST_LINK_WR;
      ST_LINK_WR: state_d = last_q ? ST_CLEAR : ST_IDLE;
      ST_CLEAR: begin
        if (cnt_q == NODE_W'(MAX_NODES - 1)) state_d = ST_ENT_START;
      end
      ST_ENT_START: state_d = ST_ENT_LVL;
      ST_ENT_LVL: begin
        if (lvl_q == LVL_W'(LOG_LEVELS - 1)) state_d = ST_ENT_WR;
      end
      ST_ENT_WR: state_d = ST_WALK_RD;
      ST_WALK_RD: begin
        if (top_q == '0) state_d = ST_IDLE;
        else if (at_limit) state_d = ST_POP;
        else state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: state_d = cur_rdata[NODE_W] ? ST_POP : ST_WALK_ADV;
      ST_WALK_ADV: begin
        if (!node_rdata.seen && !top_q[NODE_W]) state_d = ST_ENT_START;
        else state_d = ST_WALK_RD;
      end
      ST_POP: state_d = (top_q != TOP_W'(1)) ? ST_POP_WAIT : ST_WALK_RD;
      ST_POP_WAIT: state_d = ST_WALK_RD;
      ST_Q_RDA: state_d = ST_Q_RDB;
      ST_Q_RDB: state_d = ST_Q_TEST;
      ST_Q_TEST: begin
        if (a_above || b_above) state_d = ST_Q_DONE;
        else state_d = ST_LIFT_RD;
      end
      ST_LIFT_RD: state_d = ST_LIFT_CHK;
      ST_LIFT_CHK: state_d = (lvl_q == '0) ? ST_Q_DONE : ST_LIFT_RD;
      ST_Q_DONE: begin
        if (!out_busy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    fc_we = 1'b0;   fc_waddr = cnt_q;   fc_wdata = NONE_MARK;  fc_raddr = tgt_q;
    ns_we = 1'b0;   ns_waddr = a_q;     ns_wdata = fc_rdata;   ns_raddr = c_q;
    cur_we = 1'b0;  cur_waddr = tos_q;  cur_wdata = ns_rdata;  cur_raddr = tos_q;
    node_we = 1'b0; node_waddr = cnt_q; node_wdata = '0;       node_raddr = a_q;
    exit_we = 1'b0; exit_waddr = cnt_q; exit_wdata = '0;       exit_raddr = a_q;
    stk_we = 1'b0;  stk_waddr = top_q[NODE_W-1:0]; stk_wdata = tgt_q;
    stk_raddr = NODE_W'(top_q - TOP_W'(2));
    in_ready_o = 1'b0;
    res_load_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        fc_we   = 1'b1;
        node_we = 1'b1;
        exit_we = 1'b1;
      end
      ST_IDLE: in_ready_o = 1'b1;
      ST_LINK_RD: fc_raddr = b_q;
      ST_LINK_WR: begin
        ns_we    = 1'b1;
        fc_we    = 1'b1;
        fc_waddr = b_q;
        fc_wdata = {1'b0, a_q};
      end
      ST_CLEAR: begin
        node_we = 1'b1;
        exit_we = 1'b1;
      end
      ST_ENT_START: node_raddr = par_q;
      ST_ENT_LVL: node_raddr = lvl_val;
      ST_ENT_WR: begin
        node_we          = 1'b1;
        node_waddr       = tgt_q;
        node_wdata.seen  = 1'b1;
        node_wdata.entry = clock_q;
        node_wdata.anc   = anc_q;
        cur_we           = 1'b1;
        cur_waddr        = tgt_q;
        cur_wdata        = fc_rdata;
        stk_we           = 1'b1;
      end
      ST_WALK_CHK: begin
        ns_raddr   = cur_rdata[NODE_W-1:0];
        node_raddr = cur_rdata[NODE_W-1:0];
      end
      ST_WALK_ADV: cur_we = 1'b1;
      ST_POP: begin
        exit_we    = 1'b1;
        exit_waddr = tos_q;
        exit_wdata = clock_q;
      end
      ST_Q_RDB: begin
        node_raddr = b_q;
        exit_raddr = b_q;
      end
      ST_LIFT_RD: begin
        node_raddr = anc_q[lvl_q];
        exit_raddr = anc_q[lvl_q];
      end
      ST_Q_DONE: res_load_o = !out_busy_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      top_q   <= '0;
      steps_q <= '0;
      clock_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_INIT, ST_CLEAR: begin
          cnt_q   <= cnt_q + NODE_W'(1);
          top_q   <= '0;
          steps_q <= '0;
          clock_q <= '0;
        end
        ST_IDLE: cnt_q <= '0;
        ST_ENT_WR: begin
          clock_q <= clock_q + TIME_W'(1);
          top_q   <= top_q + TOP_W'(1);
        end
        ST_WALK_CHK: steps_q <= steps_q + STEP_W'(1);
        ST_POP: begin
          if (!flush_q) clock_q <= clock_q + TIME_W'(1);
          top_q <= top_q - TOP_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        a_q    <= in_word_i.node;
        b_q    <= in_word_i.other_node;
        last_q <= in_word_i.last;
        res_q  <= '0;
      end
      ST_CLEAR: begin
        par_q <= '0;
        tgt_q <= '0;
      end
      ST_ENT_START: begin
        anc_q[0] <= par_q;
        lvl_q    <= LVL_W'(1);
      end
      ST_ENT_LVL: begin
        anc_q[lvl_q] <= lvl_val;
        lvl_q        <= lvl_q + LVL_W'(1);
      end
      ST_ENT_WR: tos_q <= tgt_q;
      // pops forced by the step limit keep the clock
      ST_WALK_RD: flush_q <= at_limit;
      ST_WALK_CHK: c_q <= cur_rdata[NODE_W-1:0];
      ST_WALK_ADV: begin
        par_q <= tos_q;
        tgt_q <= c_q;
      end
      ST_POP_WAIT: tos_q <= stk_rdata;
      ST_Q_RDB: begin
        anc_q <= node_rdata.anc;
        ea_q  <= node_rdata.entry;
        xa_q  <= exit_rdata;
      end
      ST_Q_TEST: begin
        eb_q  <= node_rdata.entry;
        xb_q  <= exit_rdata;
        lvl_q <= LVL_W'(LOG_LEVELS - 1);
        if (a_above) res_q <= a_q;
        else if (b_above) res_q <= b_q;
      end
      ST_LIFT_CHK: begin
        if (!up_above) anc_q <= node_rdata.anc;
        lvl_q <= lvl_q - LVL_W'(1);
        res_q <= up_above ? anc_q[0] : node_rdata.anc[0];
      end
      default: ;
    endcase
  end

  // ST_Q_TEST checks a above b against b's freshly read times
  assign res_o = res_q;

endmodule

// ===== src/tree_lca_binary_lifting.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// lowest common ancestor engine: child linking, depth-first build of
// entry/exit times and ancestor rows, and binary lifting queries
// ----------------------------------------------------------------------------
// channel     dir   word
// in_i        in    kind, node, other_node, last
// out_o       out   ancestor
// cfg         in    cfg_we_i, cfg_wdata_i (node_count)
//
// a parent entry passes the link read and link write states; a query does one node
// memory read per lifting level.
// a build first clears the node rows and exit times, then walks every node reached.
// after reset a pass clears the child links and node rows; no word is taken then.
// a finished answer waits in the output register; the next word is taken
// meanwhile, and a new answer waits for that register to drain.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lcabl_in_if.sink                    in_i,
  lcabl_out_if.source                 out_o,
  input  logic                        cfg_we_i,
  input  logic [lcabl_pkg::CFG_W-1:0] cfg_wdata_i
);
  import lcabl_pkg::*;

  logic [CFG_W-1:0]  node_count_q;
  logic              out_valid_q;
  logic [NODE_W-1:0] out_word_q;
  logic              res_load, out_busy;
  logic [NODE_W-1:0] res;
  in_word_t          in_word;

  assign in_word.kind       = in_i.kind;
  assign in_word.node       = in_i.node;
  assign in_word.other_node = in_i.other_node;
  assign in_word.last       = in_i.last;

  // clamp node count into range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) node_count_q <= CFG_W'(1);
      else if (cfg_wdata_i > CFG_W'(MAX_NODES)) node_count_q <= CFG_W'(MAX_NODES);
      else node_count_q <= cfg_wdata_i;
    end
  end

  assign out_busy = out_valid_q && !out_o.ready;

  lcabl_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_word_i    (in_word),
    .node_count_i (node_count_q),
    .out_busy_i   (out_busy),
    .res_load_o   (res_load),
    .res_o        (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_word_q <= res;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.ancestor = out_word_q;

endmodule

// ===== test/tree_lca_binary_lifting_tb.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_tb
// self-checking bench for the lowest common ancestor engine: builds random
// trees through parent entries, queries node pairs and compares every answer
// with a software copy of the linking, depth-first build and lifting search
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_tb;
  import lcabl_pkg::*;

  localparam int LIMIT = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  lcabl_in_if  in_ch ();
  lcabl_out_if out_ch ();

  tree_lca_binary_lifting DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // software copy of the engine
  int unsigned nodes_used;
  int unsigned kid_head [MAX_NODES];
  int unsigned sib_link [MAX_NODES];
  int unsigned up_row   [MAX_NODES][LOG_LEVELS];
  int unsigned t_in     [MAX_NODES];
  int unsigned t_out    [MAX_NODES];
  int unsigned lca_q [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic bit covers(int unsigned a, int unsigned b);
    return t_in[a] <= t_in[b] && t_out[a] >= t_out[b];
  endfunction

  function automatic void rebuild_times();
    int unsigned stk [MAX_NODES];
    int unsigned cur [MAX_NODES];
    bit visited [MAX_NODES];
    int unsigned top, steps, clk_v, v, c, p;
    for (int i = 0; i < MAX_NODES; i++) begin
      t_in[i] = 0; t_out[i] = 0; visited[i] = 0; cur[i] = 0;
      for (int l = 0; l < LOG_LEVELS; l++) up_row[i][l] = 0;
    end
    clk_v = 0; top = 0; steps = 0;
    v = 0; p = 0;
    visited[v] = 1; t_in[v] = clk_v++; up_row[v][0] = p;
    for (int l = 1; l < LOG_LEVELS; l++) up_row[v][l] = up_row[up_row[v][l-1]][l-1];
    cur[v] = kid_head[v];
    stk[top++] = 0;
    while (top > 0 && steps < STEP_LIMIT) begin
      v = stk[top-1];
      c = cur[v];
      steps++;
      if (c < MAX_NODES) begin
        cur[v] = sib_link[c];
        if (!visited[c] && top < MAX_NODES) begin
          visited[c] = 1; t_in[c] = clk_v++; up_row[c][0] = v;
          for (int l = 1; l < LOG_LEVELS; l++)
            up_row[c][l] = up_row[up_row[c][l-1]][l-1];
          cur[c] = kid_head[c];
          stk[top++] = c;
        end
      end else begin
        t_out[v] = clk_v++;
        top--;
      end
    end
    while (top > 0) begin
      top--;
      t_out[stk[top]] = clk_v;
    end
  endfunction

  function automatic int unsigned lowest_common(int unsigned a, int unsigned b);
    int unsigned u;
    if (a >= nodes_used || b >= nodes_used) return 0;
    if (covers(a, b)) return a;
    if (covers(b, a)) return b;
    for (int l = LOG_LEVELS - 1; l >= 0; l--) begin
      u = up_row[a][l];
      if (!covers(u, b)) a = u;
    end
    return up_row[a][0];
  endfunction

  function automatic void absorb(bit kind, int unsigned a, int unsigned b, bit lst);
    if (kind == KIND_ENTRY) begin
      if (a != 0 && a != b && a < nodes_used && b < nodes_used) begin
        sib_link[a] = kid_head[b];
        kid_head[b] = a;
      end
      if (lst) rebuild_times();
    end else begin
      lca_q = {lca_q, lowest_common(a, b)};
    end
  endfunction

  task automatic send_word(bit kind, int unsigned a, int unsigned b, bit lst);
    bit idle;
    idle = !quiet && ($urandom_range(99) < 30);
    if (idle) in_ch.valid <= 1'b0;
    while (idle) begin
      @(posedge clk_i);
      idle = ($urandom_range(99) < 30);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.node       <= a[NODE_W-1:0];
    in_ch.other_node <= b[NODE_W-1:0];
    in_ch.last       <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    absorb(kind, a, b, lst);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (lca_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_nodes(int unsigned n);
    int unsigned v;
    drain();
    v = n;
    if (v < 1) v = 1;
    if (v > MAX_NODES) v = MAX_NODES;
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    nodes_used = v;
  endtask

  // random tree over nodes 1..n-1 under earlier nodes, with some noise entries
  task automatic grow_tree(int unsigned n, bit noisy);
    int unsigned p;
    for (int unsigned c = 1; c < n; c++) begin
      p = $urandom_range(c - 1);
      if (noisy && $urandom_range(9) == 0)
        send_word(KIND_ENTRY, $urandom_range(1023), $urandom_range(1023), 1'b0);
      send_word(KIND_ENTRY, c, p, 1'b0);
    end
    send_word(KIND_ENTRY, 0, 0, 1'b1);
  endtask

  task automatic ask_random(int count, int unsigned n);
    int unsigned a, b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) begin
        a = $urandom_range(1023); b = $urandom_range(1023);
      end else begin
        a = $urandom_range(n - 1); b = $urandom_range(n - 1);
      end
      send_word(KIND_QUERY, a, b, $urandom_range(1));
    end
  endtask

  task automatic test_directed();
    send_word(KIND_QUERY, 0, 0, 1'b0);
    send_word(KIND_QUERY, 5, 3, 1'b1);
    set_nodes(0);
    send_word(KIND_ENTRY, 0, 0, 1'b1);
    send_word(KIND_QUERY, 0, 0, 1'b0);
    set_nodes(8);
    send_word(KIND_QUERY, 3, 6, 1'b0);
    send_word(KIND_ENTRY, 1, 0, 1'b0);
    send_word(KIND_ENTRY, 2, 1, 1'b0);
    send_word(KIND_ENTRY, 3, 1, 1'b0);
    send_word(KIND_ENTRY, 0, 2, 1'b0);
    send_word(KIND_ENTRY, 4, 4, 1'b0);
    send_word(KIND_ENTRY, 9, 1, 1'b0);
    send_word(KIND_ENTRY, 5, 1023, 1'b0);
    send_word(KIND_ENTRY, 6, 5, 1'b0);
    send_word(KIND_ENTRY, 5, 6, 1'b1);
    send_word(KIND_QUERY, 2, 3, 1'b0);
    send_word(KIND_QUERY, 3, 3, 1'b0);
    send_word(KIND_QUERY, 1, 2, 1'b1);
    send_word(KIND_QUERY, 5, 2, 1'b0);
    send_word(KIND_QUERY, 6, 7, 1'b0);
    send_word(KIND_QUERY, 1023, 2, 1'b0);
    send_word(KIND_QUERY, 2, 1023, 1'b0);
  endtask

  task automatic test_trees();
    int unsigned n;
    for (int r = 0; r < 12; r++) begin
      n = (r == 5) ? 400 : $urandom_range(2, 40);
      set_nodes(n);
      grow_tree(n, 1'b1);
      ask_random(25, n);
      if (r == 3) begin
        drain();
        quiet = 1'b1;
      end
      if (r == 7) quiet = 1'b0;
    end
    // links persist: add nodes to the existing tree and rebuild
    n = nodes_used;
    set_nodes(2047);
    send_word(KIND_ENTRY, 1023, 0, 1'b0);
    send_word(KIND_ENTRY, 1, 1023, 1'b1);
    ask_random(40, 1024);
  endtask

  always @(posedge clk_i) begin
    int unsigned want;
    if (out_ch.valid && out_ch.ready) begin
      if (lca_q.size() == 0) begin
        $display("%0t unexpected ancestor %0d", $time, out_ch.ancestor);
        errors++;
      end else begin
        want = lca_q.pop_front();
        if (out_ch.ancestor !== want[NODE_W-1:0]) begin
          $display("%0t ancestor expected %0d actual %0d", $time, want, out_ch.ancestor);
          errors++;
        end
      end
    end
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.node = '0;
    in_ch.other_node = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    nodes_used = 1;
    for (int i = 0; i < MAX_NODES; i++) begin
      kid_head[i] = MAX_NODES; sib_link[i] = 0; t_in[i] = 0; t_out[i] = 0;
      for (int l = 0; l < LOG_LEVELS; l++) up_row[i][l] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_trees();
    drain();
    if (errors == 0 && lca_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
